>>> src/cgace_pkg.sv
// ----------------------------------------------------------------------------
// cgace_pkg: shared definitions for the column group allocator
// Sizes, operation and register select codes, tile-control bits, and the
// structs passed between the sequencer and the data unit.
// ----------------------------------------------------------------------------
package cgace_pkg;

  localparam int COLUMN_COUNT      = 32;
  localparam int COLUMNS_PER_GROUP = 4;
  localparam int BANK_WORDS        = 131072;
  localparam int TILE_COUNT        = COLUMN_COUNT / 2;

  localparam int COL_W  = $clog2(COLUMN_COUNT);
  localparam int TILE_W = 4;
  localparam int END_W  = 8;   // holds rounded start plus 15 groups
  localparam int OP_W   = 2;
  localparam int GRP_W  = 4;
  localparam int BSW_W  = 16;
  localparam int COFF_W = 5;
  localparam int IOSZ_W = 22;
  localparam int DEST_W = 2;
  localparam int SEL_W  = 4;
  localparam int DATA_W = 32;
  localparam int TC_W   = 11;
  localparam int STEP_W = 2;

  localparam logic [DATA_W-1:0] TILE_STRIDE = DATA_W'(2 * BANK_WORDS);
  localparam logic [DATA_W-1:0] BANK_SPAN   = DATA_W'(BANK_WORDS);

  // operations
  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_INPUT  = 2'd1;
  localparam logic [OP_W-1:0] OP_OUTPUT = 2'd2;
  localparam logic [OP_W-1:0] OP_FINISH = 2'd3;

  // destination lists
  localparam logic [DEST_W-1:0] DEST_BITSTREAM = 2'd0;
  localparam logic [DEST_W-1:0] DEST_IO        = 2'd1;
  localparam logic [DEST_W-1:0] DEST_TILE_CTRL = 2'd2;

  // register selects
  localparam logic [SEL_W-1:0] SEL_PCFG_START = 4'd0;
  localparam logic [SEL_W-1:0] SEL_PCFG_COUNT = 4'd1;
  localparam logic [SEL_W-1:0] SEL_LD_START   = 4'd2;
  localparam logic [SEL_W-1:0] SEL_LD_ITER    = 4'd3;
  localparam logic [SEL_W-1:0] SEL_LD_VALID   = 4'd4;
  localparam logic [SEL_W-1:0] SEL_ST_START   = 4'd5;
  localparam logic [SEL_W-1:0] SEL_ST_WORDS   = 4'd6;
  localparam logic [SEL_W-1:0] SEL_ST_VALID   = 4'd7;
  localparam logic [SEL_W-1:0] SEL_TILE_CTRL  = 4'd8;

  // tile-control bits
  localparam logic [TC_W-1:0] TC_ALLOC  = TC_W'(1 << 10);
  localparam logic [TC_W-1:0] TC_INPUT  = TC_W'((1 << 6) | (1 << 2));
  localparam logic [TC_W-1:0] TC_OUTPUT = TC_W'((1 << 8) | (1 << 5));

  typedef struct packed {
    logic              zero;
    logic              first_in;
    logic [SEL_W-1:0]  sel;
    logic [TILE_W-1:0] tile;
    logic [BSW_W-1:0]  kbsw;
    logic [IOSZ_W-1:0] iosz;
    logic [TC_W-1:0]   entry;
  } dp_ctrl_t;

  typedef struct packed {
    logic              accepted;
    logic              write_valid;
    logic [DEST_W-1:0] destination;
    logic [TILE_W-1:0] target_tile;
    logic [SEL_W-1:0]  register_select;
    logic [DATA_W-1:0] register_data;
    logic              last;
  } result_t;

endpackage

>>> src/cgace_if.sv
// ----------------------------------------------------------------------------
// cgace_if: request and result channels
// Valid/ready channels; a transaction moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface cgace_req_if;
  logic                         valid;
  logic                         ready;
  logic [cgace_pkg::OP_W-1:0]   operation;
  logic [cgace_pkg::GRP_W-1:0]  group_count;
  logic [cgace_pkg::BSW_W-1:0]  bitstream_words;
  logic [cgace_pkg::COFF_W-1:0] column_offset;
  logic [cgace_pkg::IOSZ_W-1:0] io_size;

  modport source (output valid, operation, group_count, bitstream_words,
                  column_offset, io_size, input ready);
  modport sink   (input valid, operation, group_count, bitstream_words,
                  column_offset, io_size, output ready);
endinterface

interface cgace_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         accepted;
  logic                         write_valid;
  logic [cgace_pkg::DEST_W-1:0] destination;
  logic [cgace_pkg::TILE_W-1:0] target_tile;
  logic [cgace_pkg::SEL_W-1:0]  register_select;
  logic [cgace_pkg::DATA_W-1:0] register_data;
  logic                         last;

  modport source (output valid, accepted, write_valid, destination, target_tile,
                  register_select, register_data, last, input ready);
  modport sink   (input valid, accepted, write_valid, destination, target_tile,
                  register_select, register_data, last, output ready);
endinterface

>>> src/column_group_allocator_config_emitter_unit.sv
// ----------------------------------------------------------------------------
// column_group_allocator_config_emitter_unit: column allocator, write emitter
// Hands out column groups to kernels and emits buffer-tile register writes.
// ----------------------------------------------------------------------------
// Usage:
//   req_i takes one command transaction (allocate, place input, place output,
//   finish); rsp_o returns one transaction per register write, with last set
//   on the final one of a command. A rejected command gives one result with
//   accepted low.
//   Allocate scans the column-used flags one column per cycle up to the first
//   free column, then checks the group range and emits two writes. Place
//   input/output check the column and emit three writes.
//   Finish walks the tiles one per cycle up to the last nonzero entry and
//   emits each nonzero entry as it passes it, waiting while the output is full.
//   Every result value goes through one shared adder, one per unstalled cycle.
//   req_i.ready is high only while the sequencer is idle; the next command is
//   taken while the last result still sits in the output register.
//   A stalled receiver holds the output register and the sequencer waits before its next result.
//   Reset clears all column flags, the tile-control table and kernel state;
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
module column_group_allocator_config_emitter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  cgace_req_if.sink   req_i,
  cgace_rsp_if.source rsp_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_IOCHK = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_REJ   = 3'd6;

  localparam int CC = cgace_pkg::COLUMN_COUNT;
  localparam int TC = cgace_pkg::TILE_COUNT;

  // sequencer
  logic [2:0] state_q, state_d;
  logic [cgace_pkg::COL_W-1:0]  scan_q, scan_d;
  logic [cgace_pkg::COL_W-1:0]  start_q, start_d;
  logic [cgace_pkg::STEP_W-1:0] step_q, step_d;
  logic [cgace_pkg::TILE_W-1:0] tile_q, tile_d;
  logic first_in_q, first_in_d;

  // captured command
  logic [cgace_pkg::OP_W-1:0]   op_q, op_d;
  logic [cgace_pkg::GRP_W-1:0]  grp_q, grp_d;
  logic [cgace_pkg::BSW_W-1:0]  bsw_q, bsw_d;
  logic [cgace_pkg::COFF_W-1:0] coff_q, coff_d;
  logic [cgace_pkg::IOSZ_W-1:0] iosz_q, iosz_d;

  // allocator state
  logic [CC-1:0] col_used_q, col_used_d;
  logic [TC-1:0] flag_a_q, flag_a_d;
  logic [TC-1:0] flag_i_q, flag_i_d;
  logic [TC-1:0] flag_o_q, flag_o_d;
  logic [cgace_pkg::COL_W-1:0] first_col_q, first_col_d;
  logic active_q, active_d;
  logic seen_q, seen_d;
  logic [cgace_pkg::BSW_W-1:0] kbsw_q, kbsw_d;

  // output register
  logic               out_valid_q;
  cgace_pkg::result_t out_q;
  cgace_pkg::result_t res_meta;
  cgace_pkg::result_t res_load;
  logic               load_out;
  logic               out_free;

  cgace_pkg::dp_ctrl_t          dp;
  logic [cgace_pkg::DATA_W-1:0] dp_data;

  logic                         accept;
  logic [cgace_pkg::END_W-1:0]  rounded;
  logic [cgace_pkg::END_W-1:0]  end_col;
  logic [cgace_pkg::END_W-1:0]  io_col;
  logic [cgace_pkg::TILE_W-1:0] alloc_tile;
  logic [cgace_pkg::TILE_W-1:0] io_tile;
  logic [cgace_pkg::TILE_W-1:0] fin_tile;
  logic [TC-1:0]                nz;
  logic [TC-1:0]                nz_above;
  logic                         fin_last;
  logic [cgace_pkg::TC_W-1:0]   entry;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);

  // group rounding and range arithmetic
  assign rounded = cgace_pkg::END_W'(((int'(start_q) + cgace_pkg::COLUMNS_PER_GROUP - 1)
                   / cgace_pkg::COLUMNS_PER_GROUP) * cgace_pkg::COLUMNS_PER_GROUP);
  assign end_col = rounded + cgace_pkg::END_W'(grp_q)
                   * cgace_pkg::END_W'(cgace_pkg::COLUMNS_PER_GROUP);
  assign io_col  = cgace_pkg::END_W'(first_col_q) + cgace_pkg::END_W'(coff_q);
  assign alloc_tile = rounded[cgace_pkg::TILE_W:1];
  assign io_tile    = io_col[cgace_pkg::TILE_W:1];

  // tile-control table, kept as one flag per kind and tile
  assign fin_tile = scan_q[cgace_pkg::TILE_W-1:0];
  assign nz       = flag_a_q | flag_i_q | flag_o_q;
  assign nz_above = nz >> fin_tile;
  assign fin_last = (nz_above[TC-1:1] == '0);
  assign entry    = (flag_a_q[fin_tile] ? cgace_pkg::TC_ALLOC  : '0)
                  | (flag_i_q[fin_tile] ? cgace_pkg::TC_INPUT  : '0)
                  | (flag_o_q[fin_tile] ? cgace_pkg::TC_OUTPUT : '0);

  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    start_d     = start_q;
    step_d      = step_q;
    tile_d      = tile_q;
    first_in_d  = first_in_q;
    op_d        = op_q;
    grp_d       = grp_q;
    bsw_d       = bsw_q;
    coff_d      = coff_q;
    iosz_d      = iosz_q;
    col_used_d  = col_used_q;
    flag_a_d    = flag_a_q;
    flag_i_d    = flag_i_q;
    flag_o_d    = flag_o_q;
    first_col_d = first_col_q;
    active_d    = active_q;
    seen_d      = seen_q;
    kbsw_d      = kbsw_q;
    load_out    = 1'b0;
    res_meta    = '0;
    dp          = '0;
    dp.zero     = 1'b1;
    dp.tile     = tile_q;
    dp.kbsw     = kbsw_q;
    dp.iosz     = iosz_q;
    dp.first_in = first_in_q;
    dp.entry    = entry;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d   = req_i.operation;
          grp_d  = req_i.group_count;
          bsw_d  = req_i.bitstream_words;
          coff_d = req_i.column_offset;
          iosz_d = req_i.io_size;
          scan_d = '0;
          priority if (req_i.operation == cgace_pkg::OP_ALLOC) begin
            state_d = S_SCAN;
          end else if (req_i.operation == cgace_pkg::OP_FINISH) begin
            state_d = S_FIN;
          end else begin
            state_d = S_IOCHK;
          end
        end
      end

      S_SCAN: begin
        // first free column, one per cycle
        if (!col_used_q[scan_q]) begin
          start_d = scan_q;
          state_d = S_CHECK;
        end else if (scan_q == cgace_pkg::COL_W'(CC - 1)) begin
          state_d = S_REJ;
        end else begin
          scan_d = scan_q + cgace_pkg::COL_W'(1);
        end
      end

      S_CHECK: begin
        if (rounded >= cgace_pkg::END_W'(CC) || end_col > cgace_pkg::END_W'(CC)) begin
          state_d = S_REJ;
        end else begin
          for (int i = 0; i < CC; i++) begin
            if (cgace_pkg::END_W'(i) >= rounded && cgace_pkg::END_W'(i) < end_col) begin
              col_used_d[i] = 1'b1;
            end
          end
          first_col_d          = rounded[cgace_pkg::COL_W-1:0];
          active_d             = 1'b1;
          seen_d               = 1'b0;
          kbsw_d               = bsw_q;
          tile_d               = alloc_tile;
          flag_a_d[alloc_tile] = 1'b1;
          step_d               = '0;
          state_d              = S_EMIT;
        end
      end

      S_IOCHK: begin
        if (!active_q || io_col >= cgace_pkg::END_W'(CC)) begin
          state_d = S_REJ;
        end else begin
          tile_d  = io_tile;
          step_d  = '0;
          state_d = S_EMIT;
          if (op_q == cgace_pkg::OP_INPUT) begin
            first_in_d        = !seen_q;
            seen_d            = 1'b1;
            flag_i_d[io_tile] = 1'b1;
          end else begin
            flag_o_d[io_tile] = 1'b1;
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          load_out             = 1'b1;
          dp.zero              = 1'b0;
          res_meta.accepted    = 1'b1;
          res_meta.write_valid = 1'b1;
          res_meta.target_tile = tile_q;
          if (op_q == cgace_pkg::OP_ALLOC) begin
            res_meta.destination = cgace_pkg::DEST_BITSTREAM;
            dp.sel = (step_q == '0) ? cgace_pkg::SEL_PCFG_START : cgace_pkg::SEL_PCFG_COUNT;
            res_meta.last = (step_q != '0);
          end else begin
            res_meta.destination = cgace_pkg::DEST_IO;
            res_meta.last        = (step_q == cgace_pkg::STEP_W'(2));
            unique case (step_q)
              2'd0: dp.sel = (op_q == cgace_pkg::OP_INPUT) ? cgace_pkg::SEL_LD_START
                                                            : cgace_pkg::SEL_ST_START;
              2'd1: dp.sel = (op_q == cgace_pkg::OP_INPUT) ? cgace_pkg::SEL_LD_ITER
                                                            : cgace_pkg::SEL_ST_WORDS;
              default: dp.sel = (op_q == cgace_pkg::OP_INPUT) ? cgace_pkg::SEL_LD_VALID
                                                               : cgace_pkg::SEL_ST_VALID;
            endcase
          end
          res_meta.register_select = dp.sel;
          if (res_meta.last) begin
            state_d = S_IDLE;
          end else begin
            step_d = step_q + cgace_pkg::STEP_W'(1);
          end
        end
      end

      S_FIN: begin
        // walk tiles; empty table gives a single no-write result
        priority if (nz == '0) begin
          if (out_free) begin
            load_out          = 1'b1;
            res_meta.accepted = 1'b1;
            res_meta.last     = 1'b1;
            state_d           = S_IDLE;
          end
        end else if (!nz[fin_tile]) begin
          scan_d = scan_q + cgace_pkg::COL_W'(1);
        end else if (out_free) begin
          load_out                 = 1'b1;
          dp.zero                  = 1'b0;
          dp.sel                   = cgace_pkg::SEL_TILE_CTRL;
          res_meta.accepted        = 1'b1;
          res_meta.write_valid     = 1'b1;
          res_meta.destination     = cgace_pkg::DEST_TILE_CTRL;
          res_meta.target_tile     = fin_tile;
          res_meta.register_select = cgace_pkg::SEL_TILE_CTRL;
          res_meta.last            = fin_last;
          if (fin_last) begin
            state_d = S_IDLE;
          end else begin
            scan_d = scan_q + cgace_pkg::COL_W'(1);
          end
        end
      end

      S_REJ: begin
        if (out_free) begin
          load_out      = 1'b1;
          res_meta.last = 1'b1;
          state_d       = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  cgace_datapath u_datapath (
    .ctrl_i (dp),
    .data_o (dp_data)
  );

  always_comb begin
    res_load               = res_meta;
    res_load.register_data = dp_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_q      <= '0;
      start_q     <= '0;
      step_q      <= '0;
      tile_q      <= '0;
      first_in_q  <= 1'b0;
      col_used_q  <= '0;
      flag_a_q    <= '0;
      flag_i_q    <= '0;
      flag_o_q    <= '0;
      first_col_q <= '0;
      active_q    <= 1'b0;
      seen_q      <= 1'b0;
      kbsw_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      start_q     <= start_d;
      step_q      <= step_d;
      tile_q      <= tile_d;
      first_in_q  <= first_in_d;
      col_used_q  <= col_used_d;
      flag_a_q    <= flag_a_d;
      flag_i_q    <= flag_i_d;
      flag_o_q    <= flag_o_d;
      first_col_q <= first_col_d;
      active_q    <= active_d;
      seen_q      <= seen_d;
      kbsw_q      <= kbsw_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    grp_q  <= grp_d;
    bsw_q  <= bsw_d;
    coff_q <= coff_d;
    iosz_q <= iosz_d;
    if (load_out) begin
      out_q <= res_load;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.accepted        = out_q.accepted;
  assign rsp_o.write_valid     = out_q.write_valid;
  assign rsp_o.destination     = out_q.destination;
  assign rsp_o.target_tile     = out_q.target_tile;
  assign rsp_o.register_select = out_q.register_select;
  assign rsp_o.register_data   = out_q.register_data;
  assign rsp_o.last            = out_q.last;

  // a taken command blocks the request channel on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req_i.ready)
    else $error("request taken while a command is in progress");

  // columns are never freed
  a_cols_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (($past(col_used_q) & ~col_used_q) == '0))
    else $error("column used flag cleared");

  // a rejection carries no write and closes the command
  a_reject_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.accepted) |-> (!rsp_o.write_valid && rsp_o.last))
    else $error("malformed rejection result");

  // input tracking only exists under an active kernel
  a_seen_needs_kernel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |-> active_q)
    else $error("input seen without active kernel");

  // results come only from a working sequencer
  a_load_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (state_q != S_IDLE))
    else $error("result loaded while idle");

endmodule

>>> src/cgace_datapath.sv
// ----------------------------------------------------------------------------
// cgace_datapath: shared register-value unit
// One 32-bit adder whose operands are picked by the register select.
// ----------------------------------------------------------------------------
module cgace_datapath (
  input  cgace_pkg::dp_ctrl_t          ctrl_i,
  output logic [cgace_pkg::DATA_W-1:0] data_o
);

  logic [cgace_pkg::DATA_W-1:0] base;
  logic [cgace_pkg::DATA_W-1:0] op_a;
  logic [cgace_pkg::DATA_W-1:0] op_b;

  assign base = cgace_pkg::DATA_W'(ctrl_i.tile) * cgace_pkg::TILE_STRIDE;

  always_comb begin
    op_a = '0;
    op_b = '0;
    if (!ctrl_i.zero) begin
      unique case (ctrl_i.sel)
        cgace_pkg::SEL_PCFG_START: op_a = base;
        cgace_pkg::SEL_PCFG_COUNT: op_b = cgace_pkg::DATA_W'(ctrl_i.kbsw);
        cgace_pkg::SEL_LD_START: begin
          op_a = base;
          if (ctrl_i.first_in) op_b = cgace_pkg::DATA_W'(ctrl_i.kbsw) << 3;
        end
        cgace_pkg::SEL_LD_ITER: begin
          op_a = {ctrl_i.iosz, 10'b0};
          op_b = cgace_pkg::DATA_W'(1);
        end
        cgace_pkg::SEL_LD_VALID,
        cgace_pkg::SEL_ST_VALID: op_b = cgace_pkg::DATA_W'(1);
        cgace_pkg::SEL_ST_START: begin
          op_a = base;
          op_b = cgace_pkg::BANK_SPAN;
        end
        cgace_pkg::SEL_ST_WORDS:  op_b = cgace_pkg::DATA_W'(ctrl_i.iosz);
        cgace_pkg::SEL_TILE_CTRL: op_b = cgace_pkg::DATA_W'(ctrl_i.entry);
        default: ;
      endcase
    end
  end

  assign data_o = op_a + op_b;

endmodule
